// File: hdl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared widths and codes for the Reed-Muller codec core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmc_pkg;

   localparam int CW_WIDTH  = 64;   // codeword / received word width
   localparam int MSG_WIDTH = 22;   // generator rows for RM(2,6)
   localparam int DEC_WIDTH = 4;    // RM(1,3) message width
   localparam int RX_USED   = 8;    // RM(1,3) code length

   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // register map (word index)
   localparam logic REG_CODE_M     = 1'b0;
   localparam logic REG_CODE_ORDER = 1'b1;

   localparam logic [2:0] CODE_M_RESET     = 3'd3;
   localparam logic [1:0] CODE_ORDER_RESET = 2'd1;

   // the only setting the majority decoder handles
   localparam logic [2:0] DEC_CODE_M     = 3'd3;
   localparam logic [1:0] DEC_CODE_ORDER = 2'd1;

endpackage

`default_nettype wire

// File: hdl/reed_muller_codec_core.sv
// ----------------------------------------------------------------------------
// reed_muller_codec_core
// Reed-Muller RM(r,m) encoder and RM(1,3) majority decoder, one word per
// request, with an APB-style register port for m and r.
// ----------------------------------------------------------------------------
// Latency: a taken word passes the input register, then the result register, before rsp_strobe shows it.
// Throughput: one word per cycle; busy never rises, the input register feeds
// the encode/decode network and the result register every cycle.
// Reset: code_m returns to 3, code_order to 1, and in-flight words are dropped.
// Results are shown for one cycle only; the receiver cannot stall.
`default_nettype none

module reed_muller_codec_core #(
   parameter int MAX_M = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [rmc_pkg::MSG_WIDTH-1:0] req_message_bits,
   input  wire logic [rmc_pkg::CW_WIDTH-1:0]  req_received_word,
   // result channel
   output logic                               rsp_strobe,
   output logic      [rmc_pkg::CW_WIDTH-1:0]  rsp_codeword,
   output logic      [rmc_pkg::DEC_WIDTH-1:0] rsp_decoded_message,
   output logic                               rsp_decode_unsupported,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);

   localparam logic [2:0] MaxM = 3'(MAX_M);

   logic [2:0] code_m_ff,     code_m_in;
   logic [1:0] code_order_ff, code_order_in;

   logic                          in_valid_ff;
   logic                          in_type_ff;
   logic [rmc_pkg::MSG_WIDTH-1:0] in_msg_ff;
   logic [rmc_pkg::RX_USED-1:0]   in_rx_ff;

   logic                          out_strobe_ff;
   logic [rmc_pkg::CW_WIDTH-1:0]  out_cw_ff,  out_cw_in;
   logic [rmc_pkg::DEC_WIDTH-1:0] out_dec_ff, out_dec_in;
   logic                          out_uns_ff, out_uns_in;

   logic                          cfg_write;
   logic [2:0]                    m_eff;
   logic [rmc_pkg::CW_WIDTH-1:0]  enc_word;
   logic [rmc_pkg::DEC_WIDTH-1:0] dec_msg;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // ---------------- registers ----------------
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      code_m_in     = code_m_ff;
      code_order_in = code_order_ff;
      if (cfg_write) begin
         case (paddr[2])
            rmc_pkg::REG_CODE_M:     code_m_in     = pwdata[2:0];
            rmc_pkg::REG_CODE_ORDER: code_order_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         rmc_pkg::REG_CODE_M:     prdata = {29'd0, code_m_ff};
         rmc_pkg::REG_CODE_ORDER: prdata = {30'd0, code_order_ff};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_m_ff     <= rmc_pkg::CODE_M_RESET;
         code_order_ff <= rmc_pkg::CODE_ORDER_RESET;
      end else begin
         code_m_ff     <= code_m_in;
         code_order_ff <= code_order_in;
      end
   end

   // m clamped to 1..MAX_M
   always_comb begin
      m_eff = code_m_ff;
      if (m_eff == 3'd0) begin
         m_eff = 3'd1;
      end
      if (m_eff > MaxM) begin
         m_eff = MaxM;
      end
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         in_type_ff <= req_type;
         in_msg_ff  <= req_message_bits;
         in_rx_ff   <= req_received_word[rmc_pkg::RX_USED-1:0];
      end
   end

   // ---------------- datapath ----------------
   rmc_encode u_encode (
      .m_eff    (m_eff),
      .order    (code_order_ff),
      .message  (in_msg_ff),
      .codeword (enc_word)
   );

   rmc_decode u_decode (
      .word    (in_rx_ff),
      .message (dec_msg)
   );

   always_comb begin
      out_cw_in  = '0;
      out_dec_in = '0;
      out_uns_in = 1'b0;
      case (in_type_ff)
         rmc_pkg::REQ_ENCODE: out_cw_in = enc_word;
         rmc_pkg::REQ_DECODE: begin
            if ((code_m_ff == rmc_pkg::DEC_CODE_M) &&
                (code_order_ff == rmc_pkg::DEC_CODE_ORDER)) begin
               out_dec_in = dec_msg;
            end else begin
               out_uns_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_cw_ff  <= out_cw_in;
         out_dec_ff <= out_dec_in;
         out_uns_ff <= out_uns_in;
      end
   end

   assign rsp_strobe             = out_strobe_ff;
   assign rsp_codeword           = out_cw_ff;
   assign rsp_decoded_message    = out_dec_ff;
   assign rsp_decode_unsupported = out_uns_ff;

endmodule

`default_nettype wire

// File: hdl/rmc_encode.sv
// ----------------------------------------------------------------------------
// rmc_encode
// Combinational RM(r,m) encoder: XOR of the generator rows picked by the
// message bits, for m of 1 to 6 and order up to 2.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_encode (
   input  wire logic [2:0]                   m_eff,
   input  wire logic [1:0]                   order,
   input  wire logic [rmc_pkg::MSG_WIDTH-1:0] message,
   output logic      [rmc_pkg::CW_WIDTH-1:0]  codeword
);

   // variable row h: column j holds the inverse of bit (m-h) of j
   function automatic logic [rmc_pkg::CW_WIDTH-1:0] var_row(input logic [2:0] h,
                                                            input logic [2:0] m);
      logic [rmc_pkg::CW_WIDTH-1:0] row;
      logic [2:0]                   sh;
      logic [6:0]                   cols;
      row  = '0;
      sh   = m - h;
      cols = 7'd1 << m;
      for (int j = 0; j < rmc_pkg::CW_WIDTH; j++) begin
         if ((7'(j) < cols) && (((6'(j) >> sh) & 6'd1) == 6'd0)) begin
            row[j] = 1'b1;
         end
      end
      return row;
   endfunction

   logic [rmc_pkg::CW_WIDTH-1:0] mask;
   logic [rmc_pkg::CW_WIDTH-1:0] rows [1:6];
   logic [rmc_pkg::CW_WIDTH-1:0] word;
   logic [4:0]                   idx;
   logic [1:0]                   r;
   logic [6:0]                   cols;

   always_comb begin
      cols = 7'd1 << m_eff;
      for (int j = 0; j < rmc_pkg::CW_WIDTH; j++) begin
         mask[j] = (7'(j) < cols);
      end
      for (int h = 1; h <= 6; h++) begin
         rows[h] = var_row(3'(h), m_eff);
      end
   end

   always_comb begin
      r = (order == 2'd3) ? 2'd2 : order;
      if ({1'b0, r} > m_eff) begin
         r = m_eff[1:0];
      end

      word = message[0] ? mask : '0;
      idx  = 5'd1;
      if (r >= 2'd1) begin
         for (int h = 1; h <= 6; h++) begin
            if (3'(h) <= m_eff) begin
               if (message[idx]) begin
                  word = word ^ rows[h];
               end
               idx = idx + 5'd1;
            end
         end
      end
      // pairwise products in order (1,2),(1,3),...,(2,3),...
      if (r >= 2'd2) begin
         for (int a = 1; a <= 5; a++) begin
            for (int b = a + 1; b <= 6; b++) begin
               if (3'(b) <= m_eff) begin
                  if ((idx < 5'(rmc_pkg::MSG_WIDTH)) && message[idx]) begin
                     word = word ^ (rows[a] & rows[b]);
                  end
                  idx = idx + 5'd1;
               end
            end
         end
      end
      codeword = word & mask;
   end

endmodule

`default_nettype wire

// File: hdl/rmc_decode.sv
// ----------------------------------------------------------------------------
// rmc_decode
// Combinational RM(1,3) majority-logic decoder: four check sums per
// first-order coefficient, then a majority over the residual for a0.
// ----------------------------------------------------------------------------
`default_nettype none

module rmc_decode (
   input  wire logic [rmc_pkg::RX_USED-1:0]   word,
   output logic      [rmc_pkg::DEC_WIDTH-1:0] message
);

   localparam logic [7:0] Row1 = 8'h0F;
   localparam logic [7:0] Row2 = 8'h33;
   localparam logic [7:0] Row3 = 8'h55;

   // majority of the four check sums from rows ra and rb; ties give 1
   function automatic logic vote(input logic [7:0] w, input logic [7:0] ra,
                                 input logic [7:0] rb);
      logic [2:0] ones;
      ones = 3'(^(ra & rb & w)) + 3'(^(ra & ~rb & w))
           + 3'(^(~ra & rb & w)) + 3'(^(~ra & ~rb & w));
      return (ones >= 3'd2);
   endfunction

   logic       c1, c2, c3;
   logic [7:0] rest;
   logic [3:0] ones;

   always_comb begin
      c1   = vote(word, Row2, Row3);
      c2   = vote(word, Row1, Row3);
      c3   = vote(word, Row1, Row2);
      rest = (c1 ? Row1 : 8'h00) ^ (c2 ? Row2 : 8'h00) ^ (c3 ? Row3 : 8'h00) ^ word;
      ones = '0;
      for (int j = 0; j < 8; j++) begin
         ones = ones + 4'(rest[j]);
      end
      message = {c3, c2, c1, (ones >= 4'd4)};
   end

endmodule

`default_nettype wire

// File: bench/reed_muller_codec_checker.sv
// ----------------------------------------------------------------------------
// reed_muller_codec_checker
// Watches the request, result and register ports of the Reed-Muller codec
// core. Keeps its own copy of m and r, predicts each result word when a
// request word is taken, and compares the result words in order.
// ----------------------------------------------------------------------------
module reed_muller_codec_checker #(
   parameter int MAX_M = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic                          req_type,
   input  wire logic [rmc_pkg::MSG_WIDTH-1:0] req_message_bits,
   input  wire logic [rmc_pkg::CW_WIDTH-1:0]  req_received_word,
   input  wire logic                          rsp_strobe,
   input  wire logic [rmc_pkg::CW_WIDTH-1:0]  rsp_codeword,
   input  wire logic [rmc_pkg::DEC_WIDTH-1:0] rsp_decoded_message,
   input  wire logic                          rsp_decode_unsupported,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   input  wire logic                          pready,
   output int                                 errors,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rmc_pkg::CW_WIDTH-1:0]  codeword;
      logic [rmc_pkg::DEC_WIDTH-1:0] decoded;
      logic                          unsupported;
   } rm_word_type;

   rm_word_type expected_words[$];
   logic [2:0]  code_m     = rmc_pkg::CODE_M_RESET;
   logic [1:0]  code_order = rmc_pkg::CODE_ORDER_RESET;

   // column j set where bit (m-h) of j is clear
   function automatic logic [63:0] var_row(int h, int m);
      logic [63:0] row;
      row = '0;
      for (int j = 0; j < (1 << m); j++) begin
         if (((j >> (m - h)) & 1) == 0) row[j] = 1'b1;
      end
      return row;
   endfunction

   function automatic logic [63:0] encode_word(logic [rmc_pkg::MSG_WIDTH-1:0] msg,
                                               logic [2:0] m_raw,
                                               logic [1:0] r_raw);
      int          m;
      int          r;
      int          idx;
      logic [63:0] mask;
      logic [63:0] word;
      logic [63:0] rows [0:6];
      m = m_raw;
      if (m < 1) m = 1;
      if (m > MAX_M) m = MAX_M;
      r = r_raw;
      if (r > 2) r = 2;
      if (r > m) r = m;
      mask = (m >= 6) ? '1 : (64'd1 << (1 << m)) - 64'd1;
      rows[0] = mask;
      for (int h = 1; h <= 6; h++) rows[h] = (h <= m) ? var_row(h, m) : '0;
      word = '0;
      if (msg[0]) word ^= rows[0];
      idx = 1;
      if (r >= 1) begin
         for (int h = 1; h <= m; h++) begin
            if (msg[idx]) word ^= rows[h];
            idx++;
         end
      end
      if (r >= 2) begin
         for (int a = 1; a <= m; a++) begin
            for (int b = a + 1; b <= m; b++) begin
               if (idx < rmc_pkg::MSG_WIDTH && msg[idx]) word ^= rows[a] & rows[b];
               idx++;
            end
         end
      end
      return word & mask;
   endfunction

   // majority of the four check sums over rows a, b and their complements
   function automatic logic pair_vote(logic [7:0] w, logic [7:0] ra, logic [7:0] rb);
      int         ones;
      logic [7:0] xa;
      logic [7:0] xb;
      ones = 0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            xa = (i != 0) ? ~ra : ra;
            xb = (j != 0) ? ~rb : rb;
            if (^(xa & xb & w)) ones++;
         end
      end
      return ones >= 2;
   endfunction

   function automatic logic [rmc_pkg::DEC_WIDTH-1:0] decode_rm13(logic [7:0] w);
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
      logic [7:0]  rest;
      logic        c1;
      logic        c2;
      logic        c3;
      logic        a0;
      v1 = var_row(1, 3);
      v2 = var_row(2, 3);
      v3 = var_row(3, 3);
      c1 = pair_vote(w, v2[7:0], v3[7:0]);
      c2 = pair_vote(w, v1[7:0], v3[7:0]);
      c3 = pair_vote(w, v1[7:0], v2[7:0]);
      rest = '0;
      if (c1) rest ^= v1[7:0];
      if (c2) rest ^= v2[7:0];
      if (c3) rest ^= v3[7:0];
      // ties go to 1
      a0 = $countones(rest ^ w) >= 4;
      return {c3, c2, c1, a0};
   endfunction

   always @(posedge clock) begin
      rm_word_type want;
      rm_word_type got;
      if (reset) begin
         code_m     = rmc_pkg::CODE_M_RESET;
         code_order = rmc_pkg::CODE_ORDER_RESET;
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            if (paddr[2] == rmc_pkg::REG_CODE_M) code_m = pwdata[2:0];
            else code_order = pwdata[1:0];
         end
         if (start && !busy) begin
            want = '0;
            if (req_type == rmc_pkg::REQ_ENCODE)
               want.codeword = encode_word(req_message_bits, code_m, code_order);
            else if (code_m == rmc_pkg::DEC_CODE_M &&
                     code_order == rmc_pkg::DEC_CODE_ORDER)
               want.decoded = decode_rm13(req_received_word[rmc_pkg::RX_USED-1:0]);
            else
               want.unsupported = 1'b1;
            expected_words.push_back(want);
         end
         if (rsp_strobe) begin
            got = {rsp_codeword, rsp_decoded_message, rsp_decode_unsupported};
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result word with none pending: codeword %h dec %h unsup %b",
                           $realtime, got.codeword, got.decoded, got.unsupported);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: codeword %h/%h dec %h/%h unsup %b/%b (exp/act)",
                              $realtime, want.codeword, got.codeword, want.decoded,
                              got.decoded, want.unsupported, got.unsupported);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// File: bench/reed_muller_codec_core_tb.sv
// ----------------------------------------------------------------------------
// reed_muller_codec_core_tb
// Drives encode and decode words into the Reed-Muller codec core across a
// range of m and r settings, directed corners first, then random words under
// varying sender gaps. The checker beside the core judges every result word.
// ----------------------------------------------------------------------------
module reed_muller_codec_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_M     = 6;
   localparam int SEGMENTS  = 12;
   localparam int SEG_WORDS = 58;

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          start             = 1'b0;
   logic                          req_type          = rmc_pkg::REQ_ENCODE;
   logic [rmc_pkg::MSG_WIDTH-1:0] req_message_bits  = '0;
   logic [rmc_pkg::CW_WIDTH-1:0]  req_received_word = '0;
   logic                          psel              = 1'b0;
   logic                          penable           = 1'b0;
   logic                          pwrite            = 1'b0;
   logic [2:0]                    paddr             = '0;
   logic [31:0]                   pwdata            = '0;

   logic                          busy;
   logic                          rsp_strobe;
   logic [rmc_pkg::CW_WIDTH-1:0]  rsp_codeword;
   logic [rmc_pkg::DEC_WIDTH-1:0] rsp_decoded_message;
   logic                          rsp_decode_unsupported;
   logic [31:0]                   prdata;
   logic                          pready;
   int                            chk_errors;
   int                            chk_pending;

   always #5 clock = ~clock;

   reed_muller_codec_core #(
      .MAX_M(MAX_M)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_message_bits      (req_message_bits),
      .req_received_word     (req_received_word),
      .rsp_strobe            (rsp_strobe),
      .rsp_codeword          (rsp_codeword),
      .rsp_decoded_message   (rsp_decoded_message),
      .rsp_decode_unsupported(rsp_decode_unsupported),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   reed_muller_codec_checker #(
      .MAX_M(MAX_M)
   ) u_check (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_message_bits      (req_message_bits),
      .req_received_word     (req_received_word),
      .rsp_strobe            (rsp_strobe),
      .rsp_codeword          (rsp_codeword),
      .rsp_decoded_message   (rsp_decoded_message),
      .rsp_decode_unsupported(rsp_decode_unsupported),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .pready                (pready),
      .errors                (chk_errors),
      .pending               (chk_pending)
   );

   // drop start and wait until every result word has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [2:0] val);
      logic [31:0] noise;
      noise = $urandom();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {noise[31:3], val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_code(logic [2:0] m, logic [1:0] r);
      drain();
      write_reg(rmc_pkg::REG_CODE_M, m);
      write_reg(rmc_pkg::REG_CODE_ORDER, {1'b0, r});
   endtask

   // start stays high across back-to-back words
   task automatic send_word(logic kind, logic [rmc_pkg::MSG_WIDTH-1:0] msg,
                            logic [rmc_pkg::CW_WIDTH-1:0] rx, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_type          <= kind;
      req_message_bits  <= msg;
      req_received_word <= rx;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      int                            idle;
      logic                          kind;
      logic [rmc_pkg::MSG_WIDTH-1:0] msg;
      logic [rmc_pkg::CW_WIDTH-1:0]  rx;
      logic [7:0]                    cw;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting m=3 r=1: encode corners, decode with errors and ties
      send_word(rmc_pkg::REQ_ENCODE, '0, '0, 0);
      send_word(rmc_pkg::REQ_ENCODE, '1, '1, 0);
      send_word(rmc_pkg::REQ_ENCODE, 22'h00000E, '0, 0);
      send_word(rmc_pkg::REQ_ENCODE, 22'h000001, '1, 0);
      send_word(rmc_pkg::REQ_DECODE, '1, 64'h0, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'hFF, 0);
      send_word(rmc_pkg::REQ_DECODE, '1, 64'hFFFF_FFFF_FFFF_FF00, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h0F, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h1F, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h03, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h3C, 0);

      // largest code, full second order, top message bit
      set_code(3'd6, 2'd2);
      send_word(rmc_pkg::REQ_ENCODE, '1, '0, 0);
      send_word(rmc_pkg::REQ_ENCODE, 22'h200000, '0, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h55, 0);
      // m of 0 runs as 1, order 3 runs as 2 then clipped to m
      set_code(3'd0, 2'd3);
      send_word(rmc_pkg::REQ_ENCODE, '1, '0, 0);
      send_word(rmc_pkg::REQ_DECODE, '0, '1, 0);
      // m above the maximum, order 0
      set_code(3'd7, 2'd0);
      send_word(rmc_pkg::REQ_ENCODE, '1, '0, 0);
      // decode needs exactly m=3 and r=1
      set_code(3'd3, 2'd3);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h0F, 0);
      set_code(3'd2, 2'd1);
      send_word(rmc_pkg::REQ_DECODE, '0, 64'h0F, 0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle = (seg < 4) ? 9 : (seg < 8) ? 83 : 0;
         if (seg % 3 == 0) set_code(rmc_pkg::DEC_CODE_M, rmc_pkg::DEC_CODE_ORDER);
         else set_code(3'($urandom_range(7)), 2'($urandom_range(3)));
         for (int n = 0; n < SEG_WORDS; n++) begin
            kind = 1'($urandom_range(1));
            case ($urandom_range(3))
               0:       msg = 22'($urandom());
               1:       msg = 22'd1 << $urandom_range(rmc_pkg::MSG_WIDTH - 1);
               2:       msg = $urandom_range(1) ? '1 : '0;
               default: msg = 22'($urandom()) & 22'h00007F;
            endcase
            rx = {$urandom(), $urandom()};
            // mostly valid RM(1,3) words with up to three flipped bits
            if ($urandom_range(3) != 0) begin
               cw = ($urandom_range(1) ? 8'hFF : 8'h00) ^ ($urandom_range(1) ? 8'h0F : 8'h00)
                  ^ ($urandom_range(1) ? 8'h33 : 8'h00) ^ ($urandom_range(1) ? 8'h55 : 8'h00);
               repeat ($urandom_range(3)) cw[$urandom_range(7)] ^= 1'b1;
               rx[7:0] = cw;
            end
            send_word(kind, msg, rx, idle);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (chk_errors == 0 && chk_pending == 0)
         $display("reed_muller_codec_core_tb: clean");
      else
         $display("reed_muller_codec_core_tb: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("reed_muller_codec_core_tb: errors");
      $finish;
   end

endmodule
